@@ hdl/axis_endstop_homing_sequencer_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the axis endstop homing sequencer
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef AXIS_ENDSTOP_HOMING_SEQUENCER_ASSERT_SVH
`define AXIS_ENDSTOP_HOMING_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define AEHS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define AEHS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/aehs_pkg.sv @@
// ----------------------------------------------------------------------------
// Axis endstop homing sequencer package
// Command codes and the beat types of the request and response channels.
// ----------------------------------------------------------------------------
package aehs_pkg;

   localparam int unsigned CMD_W = 4;
   localparam int unsigned POS_W = 32;

   localparam logic [CMD_W-1:0] CMD_EMPTY   = 4'd0;
   localparam logic [CMD_W-1:0] CMD_HOME    = 4'd1;
   localparam logic [CMD_W-1:0] CMD_MEASURE = 4'd2;
   localparam logic [CMD_W-1:0] CMD_SETPOS  = 4'd3;
   localparam logic [CMD_W-1:0] CMD_ZERO    = 4'd4;
   localparam logic [CMD_W-1:0] CMD_MAX     = 4'd5;
   localparam logic [CMD_W-1:0] CMD_ENABLE  = 4'd6;
   localparam logic [CMD_W-1:0] CMD_DISABLE = 4'd7;

   localparam logic signed [POS_W-1:0] STEP_PLUS  = 32'sd1;
   localparam logic signed [POS_W-1:0] STEP_MINUS = -32'sd1;

   typedef struct packed {
      logic [CMD_W-1:0]        command;
      logic                    cmd_valid;
      logic                    min_stop;
      logic                    max_stop;
      logic signed [POS_W-1:0] cur_position;
      logic signed [POS_W-1:0] cmd_value;
      logic                    want_enable;
      logic                    want_disable;
   } req_type;

   typedef struct packed {
      logic                    move_write;
      logic signed [POS_W-1:0] move_steps;
      logic                    move_down;
      logic                    pos_write;
      logic signed [POS_W-1:0] pos_new;
      logic                    length_write;
      logic signed [POS_W-1:0] axis_len;
      logic                    is_homed;
      logic                    cmd_done;
      logic                    enable_pulse;
      logic                    disable_pulse;
   } rsp_type;

endpackage

@@ hdl/aehs_if.sv @@
// ----------------------------------------------------------------------------
// Axis endstop homing sequencer channel interfaces
// Valid/ready channels for requests, responses and the home offset register.
// ----------------------------------------------------------------------------
interface aehs_req_if import aehs_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface aehs_rsp_if import aehs_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface aehs_csr_if import aehs_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ hdl/axis_endstop_homing_sequencer.sv @@
// A request beat is held in the input register until the response slot is free, then
// moves into the response register, from which its response beat leaves.
// One beat per cycle while the response side is not stalled. The seek and homed flags
// update in the same cycle that a beat moves from the input register into the response
// register. Reset (synchronous, active high) clears both pipeline valid bits, the seek
// flags, the homed flag and the home offset register; the csr channel is always ready.
// ----------------------------------------------------------------------------
// Axis endstop homing sequencer
// Per-tick command sequencer for one stepper axis: seeks endstops one step at
// a time, loads positions, reports axis length and issues driver pulses.
// ----------------------------------------------------------------------------
module axis_endstop_homing_sequencer import aehs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   aehs_req_if.sink   req_ch,
   aehs_rsp_if.source rsp_ch,
   aehs_csr_if.sink   csr_ch
);

   // Pipeline registers: an input stage and a response stage.
   logic    req_valid_ff;
   req_type req_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   // Sequencer state and the configuration register.
   logic                    seek_zero_ff, seek_zero_in;
   logic                    seek_max_ff, seek_max_in;
   logic                    homed_ff, homed_in;
   logic signed [POS_W-1:0] home_offset_ff;

   logic rsp_free;
   logic advance;
   logic signed [POS_W-1:0] pos_now;

   // The response slot is free when empty or when its beat leaves this cycle.
   // The input stage advances whenever it holds a beat and the slot is free,
   // and it takes a new beat whenever it is empty or advancing.
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign advance      = req_valid_ff && rsp_free;
   assign req_ch.ready = !req_valid_ff || rsp_free;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_ff;
   assign csr_ch.ready = 1'b1;

   // Command evaluation for the beat in the input register. Every unused
   // response field stays zero, and an invalid beat only reports the homed flag.
   always_comb begin
      rsp_in       = '0;
      seek_zero_in = seek_zero_ff;
      seek_max_in  = seek_max_ff;
      homed_in     = homed_ff;
      pos_now      = req_ff.cur_position;

      if (req_ff.cmd_valid) begin
         unique case (req_ff.command)
            CMD_EMPTY: begin
            end
            CMD_HOME, CMD_MAX: begin
               if (seek_max_ff) begin
                  if (req_ff.max_stop) begin
                     seek_max_in     = 1'b0;
                     rsp_in.cmd_done = 1'b1;
                     // Home finishes by moving back toward the home offset.
                     if (req_ff.command == CMD_HOME) begin
                        rsp_in.move_write = 1'b1;
                        rsp_in.move_steps = home_offset_ff - req_ff.cur_position;
                        rsp_in.move_down  = 1'b1;
                     end
                  end else begin
                     rsp_in.move_write = 1'b1;
                     rsp_in.move_steps = STEP_PLUS;
                  end
               end else if (req_ff.max_stop) begin
                  // Already on the max endstop: back off first.
                  rsp_in.move_write = 1'b1;
                  rsp_in.move_steps = STEP_MINUS;
                  rsp_in.move_down  = 1'b1;
               end else begin
                  seek_max_in       = 1'b1;
                  rsp_in.move_write = 1'b1;
                  rsp_in.move_steps = STEP_PLUS;
               end
            end
            CMD_MEASURE: begin
               if (seek_zero_ff) begin
                  if (req_ff.min_stop) begin
                     // Zero found: position becomes zero and the max seek starts.
                     homed_in         = 1'b1;
                     pos_now          = '0;
                     rsp_in.pos_write = 1'b1;
                     seek_zero_in     = 1'b0;
                     seek_max_in      = 1'b1;
                  end else begin
                     rsp_in.move_write = 1'b1;
                     rsp_in.move_steps = STEP_MINUS;
                     rsp_in.move_down  = 1'b1;
                  end
               end else if (!seek_max_ff) begin
                  if (req_ff.min_stop) begin
                     rsp_in.move_write = 1'b1;
                     rsp_in.move_steps = STEP_PLUS;
                  end else begin
                     seek_zero_in      = 1'b1;
                     rsp_in.move_write = 1'b1;
                     rsp_in.move_steps = STEP_MINUS;
                     rsp_in.move_down  = 1'b1;
                  end
               end
               // The max phase sees the flag as updated by the zero phase above.
               if (seek_max_in) begin
                  if (req_ff.max_stop) begin
                     seek_max_in         = 1'b0;
                     rsp_in.length_write = 1'b1;
                     rsp_in.axis_len     = pos_now;
                     rsp_in.cmd_done     = 1'b1;
                  end else begin
                     rsp_in.move_write = 1'b1;
                     rsp_in.move_steps = STEP_PLUS;
                     rsp_in.move_down  = 1'b0;
                  end
               end
            end
            CMD_SETPOS: begin
               rsp_in.pos_write = 1'b1;
               rsp_in.pos_new   = req_ff.cmd_value;
               rsp_in.cmd_done  = 1'b1;
            end
            CMD_ZERO: begin
               if (seek_zero_ff) begin
                  if (req_ff.min_stop) begin
                     homed_in         = 1'b1;
                     rsp_in.pos_write = 1'b1;
                     seek_zero_in     = 1'b0;
                     rsp_in.cmd_done  = 1'b1;
                  end else begin
                     rsp_in.move_write = 1'b1;
                     rsp_in.move_steps = STEP_MINUS;
                     rsp_in.move_down  = 1'b1;
                  end
               end else if (req_ff.min_stop) begin
                  rsp_in.move_write = 1'b1;
                  rsp_in.move_steps = STEP_PLUS;
               end else begin
                  seek_zero_in      = 1'b1;
                  rsp_in.move_write = 1'b1;
                  rsp_in.move_steps = STEP_MINUS;
                  rsp_in.move_down  = 1'b1;
               end
            end
            CMD_ENABLE: begin
               rsp_in.enable_pulse = req_ff.want_enable;
               rsp_in.cmd_done     = 1'b1;
            end
            CMD_DISABLE: begin
               rsp_in.disable_pulse = req_ff.want_disable;
               rsp_in.cmd_done      = 1'b1;
            end
            default: begin
               // Unknown commands complete at once with no other effect.
               rsp_in.cmd_done = 1'b1;
            end
         endcase
      end

      rsp_in.is_homed = homed_in;
   end

   // Control state: valid bits, flags and the home offset register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         seek_zero_ff   <= 1'b0;
         seek_max_ff    <= 1'b0;
         homed_ff       <= 1'b0;
         home_offset_ff <= '0;
      end else begin
         if (req_ch.ready) begin
            req_valid_ff <= req_ch.valid;
         end
         if (rsp_free) begin
            rsp_valid_ff <= req_valid_ff;
         end
         if (advance) begin
            seek_zero_ff <= seek_zero_in;
            seek_max_ff  <= seek_max_in;
            homed_ff     <= homed_in;
         end
         if (csr_ch.valid) begin
            home_offset_ff <= csr_ch.data;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         req_ff <= req_ch.data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

@@ hdl/aehs_checker.sv @@
// ----------------------------------------------------------------------------
// Axis endstop homing sequencer port checker
// Watches the top level ports for pipeline and homed flag behavior.
// ----------------------------------------------------------------------------
`include "axis_endstop_homing_sequencer_assert.svh"

module aehs_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_is_homed
);

   // An accepted request beat must show up as a valid response beat.
   `AEHS_ASSERT_IMPLY(a_req_to_rsp, clock, reset, req_valid && req_ready, ##2 rsp_valid, "request beat did not reach the response register")

   // A stalled response beat stays offered.
   `AEHS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response beat dropped while stalled")

   // Once reported homed, every later response stays homed.
   `AEHS_ASSERT_NEXT(a_homed_sticky, clock, reset, rsp_valid && rsp_is_homed, !rsp_valid || rsp_is_homed, "homed flag fell without reset")

   // With the response side free, the input side never backs up.
   `AEHS_ASSERT_IMPLY(a_ready_free, clock, reset, rsp_ready, req_ready, "request side stalled while response side is ready")

endmodule

bind axis_endstop_homing_sequencer aehs_checker u_aehs_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_is_homed (rsp_ch.data.is_homed)
);
